FILE: rtl/core/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the prime sieve table core.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

    // Width of the limit register and of the queried number.
    localparam int LIMIT_W = 16;
    // Working width of the sieve values: one bit above the limit so that
    // p*p and k+p never wrap.
    localparam int VAL_W = LIMIT_W + 1;
    // Width of the sieving prime: p*p stays at or below 2**LIMIT_W.
    localparam int P_W = LIMIT_W / 2 + 1;
    // Default number of marks in the table.
    localparam int DEF_TABLE_SIZE = 65536;

    // APB data width and register addresses.
    localparam int APB_DW = 32;
    localparam int APB_AW = 2;
    localparam logic [APB_AW-1:0] ADDR_LIMIT = 2'd0;

    // Reset value of the limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    // Item kinds.
    typedef enum logic {
        KIND_BUILD = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

endpackage

`default_nettype wire

FILE: rtl/core/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/prime_sieve_table_core.sv
// ----------------------------------------------------------------------------
// prime_sieve_table_core
// One-bit primality table built by the sieve of Eratosthenes, with queries.
// ----------------------------------------------------------------------------
// Usage:
//   Issue an item by raising i_start with i_kind and i_number; the item is
//   taken at an edge where i_start is high and o_busy is low. Every item
//   yields exactly one result, shown for one cycle under o_valid. The
//   receiver cannot stall; results must be taken when o_valid is high.
//   Query (kind 1): the result is registered into o_valid after the
//   registered read of the mark RAM; o_busy is high for one cycle, so no
//   new item is taken while that read is in flight.
//   Rebuild (kind 0): a fill pass writes one mark per cycle over 0..limit;
//   then, for each p with p*p <= limit whose mark is set, the multiples of
//   p from p*p up to the limit are struck. All sums but p+1 and all limit
//   checks share one adder and comparator. The limit register sits at APB
//   address 0; the user must write it only while idle, which the core does
//   not check. Limits above TABLE_SIZE-1 saturate there for rebuilds and
//   range checks. Reset (i_rst_n low, synchronous) idles the sequencer and
//   sets the limit to 65535; the marks stay undefined until the first rebuild.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sieve_table_core #(
    parameter int TABLE_SIZE = pst_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Item channel
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_kind,
    input  wire logic [pst_pkg::LIMIT_W-1:0]  i_number,
    // Result channel
    output logic                              o_valid,
    output logic                              o_is_prime,
    output logic                              o_out_of_range,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pst_pkg::APB_AW-1:0]   paddr,
    input  wire logic [pst_pkg::APB_DW-1:0]   pwdata,
    output logic      [pst_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    import pst_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int TOP = TABLE_SIZE - 1;
    // Largest index the table holds, clipped to what the limit can reach.
    localparam logic [VAL_W-1:0] TOP_V =
        (TOP > 65535) ? VAL_W'(65535) : VAL_W'(TOP);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_FILL,
        ST_PREAD,
        ST_PCHECK,
        ST_STRIKE,
        ST_NEXTP
    } t_state;

    t_state             r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [VAL_W-1:0]   r_k, n_k;       // fill index, then the struck multiple
    logic [VAL_W-1:0]   r_sq, n_sq;     // p*p, tracked incrementally
    logic [P_W-1:0]     r_p, n_p;
    logic               r_oor, n_oor;
    logic               n_valid, n_is_prime, n_out_of_range;

    logic [VAL_W-1:0]   w_lim;
    logic [VAL_W-1:0]   w_num;
    logic               w_accept;
    logic               w_cfg_wr;

    // Shared unit
    logic [VAL_W-1:0]   w_add_a, w_add_b, w_sum;
    logic [VAL_W-1:0]   w_cmp_a;
    logic               w_cmp_gt, w_cmp_eq;

    // RAM ports
    logic               w_we;
    logic [VAL_W-1:0]   w_wval, w_rval;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic               w_wdata;
    logic               w_rdata;
    logic [AW+VAL_W-1:0] w_wext, w_rext;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign o_busy   = (r_state != ST_IDLE);

    // Configuration: one register, writes take effect on the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_LIMIT);
    assign prdata   = (paddr == ADDR_LIMIT) ? {{(APB_DW-LIMIT_W){1'b0}}, r_limit}
                                            : '0;

    // Effective limit saturates at the last table entry.
    assign w_lim = ({1'b0, r_limit} < TOP_V) ? {1'b0, r_limit} : TOP_V;
    assign w_num = {1'b0, i_number};

    // Shared adder and comparator, operands picked by the sequencer state.
    always_comb begin
        w_add_a = r_k;
        w_add_b = VAL_W'(1);
        w_cmp_a = r_sq;
        case (r_state)
            ST_FILL: begin
                w_add_a = r_k;
                w_add_b = VAL_W'(1);
                w_cmp_a = r_k;
            end
            ST_STRIKE: begin
                w_add_a = r_k;
                w_add_b = VAL_W'(r_p);
                w_cmp_a = w_sum;
            end
            ST_NEXTP: begin
                w_add_a = r_sq;
                w_add_b = VAL_W'({r_p, 1'b1});
                w_cmp_a = r_sq;
            end
            ST_IDLE: begin
                w_cmp_a = w_num;
            end
            default: begin
                w_cmp_a = r_sq;
            end
        endcase
    end

    assign w_sum    = w_add_a + w_add_b;
    assign w_cmp_gt = (w_cmp_a > w_lim);
    assign w_cmp_eq = (w_cmp_a == w_lim);

    // RAM addressing: fill and strike write at r_k; query and prime check read.
    assign w_we    = (r_state == ST_FILL) || (r_state == ST_STRIKE);
    assign w_wval  = r_k;
    assign w_wdata = (r_state == ST_FILL) && (r_k >= VAL_W'(2));
    assign w_rval  = (r_state == ST_PREAD) ? VAL_W'(r_p) : w_num;
    assign w_wext  = {{AW{1'b0}}, w_wval};
    assign w_rext  = {{AW{1'b0}}, w_rval};
    assign w_waddr = w_wext[AW-1:0];
    assign w_raddr = w_rext[AW-1:0];

    pst_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        n_sq           = r_sq;
        n_p            = r_p;
        n_oor          = r_oor;
        n_valid        = 1'b0;
        n_is_prime     = 1'b0;
        n_out_of_range = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_kind == KIND_QUERY) begin
                        // Read issued this edge; hold the range check.
                        n_oor   = w_cmp_gt;
                        n_state = ST_QUERY;
                    end else begin
                        n_k     = '0;
                        n_state = ST_FILL;
                    end
                end
            end
            ST_QUERY: begin
                n_valid        = 1'b1;
                n_is_prime     = !r_oor && w_rdata;
                n_out_of_range = r_oor;
                n_state        = ST_IDLE;
            end
            ST_FILL: begin
                n_k = w_sum;
                if (w_cmp_eq) begin
                    n_p     = P_W'(2);
                    n_sq    = VAL_W'(4);
                    n_state = ST_PREAD;
                end
            end
            ST_PREAD: begin
                if (w_cmp_gt) begin
                    // Sieve done: report the rebuild.
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PCHECK;
                end
            end
            ST_PCHECK: begin
                if (w_rdata) begin
                    n_k     = r_sq;
                    n_state = ST_STRIKE;
                end else begin
                    n_state = ST_NEXTP;
                end
            end
            ST_STRIKE: begin
                n_k = w_sum;
                if (w_cmp_gt) begin
                    n_state = ST_NEXTP;
                end
            end
            ST_NEXTP: begin
                // (p+1)^2 = p^2 + 2p + 1
                n_sq    = w_sum;
                n_p     = r_p + P_W'(1);
                n_state = ST_PREAD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_limit        <= LIMIT_RESET;
            o_valid        <= 1'b0;
            o_is_prime     <= 1'b0;
            o_out_of_range <= 1'b0;
        end else begin
            r_state        <= n_state;
            o_valid        <= n_valid;
            o_is_prime     <= n_is_prime;
            o_out_of_range <= n_out_of_range;
            if (w_cfg_wr) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
        end
        r_k   <= n_k;
        r_sq  <= n_sq;
        r_p   <= n_p;
        r_oor <= n_oor;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_prime && o_out_of_range))
        else $error("out-of-range result marked prime");

    a_strike_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STRIKE) |-> (r_k <= w_lim))
        else $error("strike address beyond the limit");

endmodule

`default_nettype wire

FILE: dv/prime_sieve_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sieve_table_checker
// Watches the item, result and register channels of the sieve table core,
// keeps its own copy of the mark table and compares every result in order.
// ----------------------------------------------------------------------------
module prime_sieve_table_checker
    import pst_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_kind,
    input  logic [LIMIT_W-1:0] i_number,
    input  logic               i_valid,
    input  logic               i_is_prime,
    input  logic               i_out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    input  logic [APB_DW-1:0]  prdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic is_prime;
        logic out_of_range;
    } t_answer;

    bit                 prime_marks [TABLE_SIZE];
    logic [LIMIT_W-1:0] limit_q = LIMIT_RESET;
    t_answer            answers_due [$];
    int                 fails = 0;

    assign o_fail_count = fails;

    function automatic int sieve_top();
        return (int'(limit_q) < TABLE_SIZE - 1) ? int'(limit_q) : TABLE_SIZE - 1;
    endfunction

    // Fill 0..top, strike 0 and 1, then strike multiples of each surviving p.
    function automatic void build_prime_marks();
        int top;
        top = sieve_top();
        for (int i = 0; i <= top; i++)
            prime_marks[i] = 1'b1;
        prime_marks[0] = 1'b0;
        if (top >= 1)
            prime_marks[1] = 1'b0;
        for (int p = 2; p * p <= top; p++) begin
            if (prime_marks[p]) begin
                for (int k = p * p; k <= top; k += p)
                    prime_marks[k] = 1'b0;
            end
        end
    endfunction

    function automatic t_answer answer_for(input logic kind, input logic [LIMIT_W-1:0] number);
        t_answer ans;
        ans = '0;
        if (kind == KIND_BUILD)
            build_prime_marks();
        else if (int'(number) > sieve_top())
            ans.out_of_range = 1'b1;
        else
            ans.is_prime = prime_marks[number];
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            answers_due.delete();
            limit_q = LIMIT_RESET;
            o_pending <= 0;
        end else begin
            if (psel && penable && pready && pwrite && paddr == ADDR_LIMIT)
                limit_q = pwdata[LIMIT_W-1:0];
            if (psel && penable && pready && !pwrite && paddr == ADDR_LIMIT
                    && prdata !== APB_DW'(limit_q)) begin
                fails++;
                $error("limit readback: expected %0h, got %0h", APB_DW'(limit_q), prdata);
            end
            if (i_valid) begin
                if (answers_due.size() == 0) begin
                    fails++;
                    $error("result with no item outstanding");
                end else begin
                    want = answers_due.pop_front();
                    if (i_is_prime !== want.is_prime) begin
                        fails++;
                        $error("is_prime: expected %0b, got %0b", want.is_prime, i_is_prime);
                    end
                    if (i_out_of_range !== want.out_of_range) begin
                        fails++;
                        $error("out_of_range: expected %0b, got %0b",
                               want.out_of_range, i_out_of_range);
                    end
                end
            end
            if (i_start && !i_busy)
                answers_due.push_back(answer_for(i_kind, i_number));
            o_pending <= answers_due.size();
        end
    end

endmodule

FILE: dv/tb_prime_sieve_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_sieve_table_core
// Drives rebuild and query items plus limit writes into the sieve table core;
// a checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_prime_sieve_table_core;
    import pst_pkg::*;

    localparam int TABLE_SIZE   = DEF_TABLE_SIZE;
    localparam int TOP_NUMBER   = 2 ** LIMIT_W - 1;
    localparam int RANDOM_ITEMS = 1800;
    // Quiet cycles after the last result, to catch any stray result strobe.
    localparam int DRAIN_CYCLES = 16;
    // Watchdog time for the whole run, in nanoseconds.
    localparam int RUN_LIMIT_NS = 100_000_000;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_start        = 1'b0;
    logic               i_kind         = KIND_QUERY;
    logic [LIMIT_W-1:0] i_number       = '0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [APB_AW-1:0]  paddr          = ADDR_LIMIT;
    logic [APB_DW-1:0]  pwdata         = '0;
    logic               o_busy;
    logic               o_valid;
    logic               o_is_prime;
    logic               o_out_of_range;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    // Stimulus-side view of the block: the limit register as last written
    // and the highest mark any rebuild has written so far.
    int cur_limit   = LIMIT_RESET;
    int max_built   = -1;
    int burst_left  = 0;
    int random_sent = 0;

    prime_sieve_table_core #(
        .TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_kind        (i_kind),
        .i_number      (i_number),
        .o_valid       (o_valid),
        .o_is_prime    (o_is_prime),
        .o_out_of_range(o_out_of_range),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    prime_sieve_table_checker #(
        .TABLE_SIZE(TABLE_SIZE)
    ) sieve_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_kind        (i_kind),
        .i_number      (i_number),
        .i_valid       (o_valid),
        .i_is_prime    (o_is_prime),
        .i_out_of_range(o_out_of_range),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("** prime_sieve_table_core: FAILED **");
        $finish;
    end

    function automatic int eff_limit(input int lim);
        return (lim < TABLE_SIZE - 1) ? lim : TABLE_SIZE - 1;
    endfunction

    // Pick a query number: mostly inside the table, some on the limit edge,
    // some beyond it. Never aim at a mark that no rebuild has written yet.
    function automatic int pick_query();
        int lim;
        int reach;
        int n;
        int r;
        lim   = eff_limit(cur_limit);
        reach = (lim < max_built) ? lim : max_built;
        r     = $urandom_range(99);
        if (r < 55) begin
            n = $urandom_range(reach, 0);
        end else if (r < 70) begin
            case ($urandom_range(4))
                0:       n = cur_limit;
                1:       n = cur_limit + 1;
                2:       n = 0;
                3:       n = 1;
                default: n = 2;
            endcase
            if (n > TOP_NUMBER)
                n = TOP_NUMBER;
        end else if (r < 85 && lim < TOP_NUMBER) begin
            n = $urandom_range(TOP_NUMBER, lim + 1);
        end else begin
            n = $urandom_range(TOP_NUMBER);
        end
        if (n <= lim && n > reach)
            n = reach;
        return n;
    endfunction

    // Keep most limits small so rebuilds stay short; touch the low extremes
    // now and then.
    function automatic int pick_limit();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return $urandom_range(3);
        else if (r < 50)
            return $urandom_range(64, 4);
        else if (r < 85)
            return $urandom_range(2048, 65);
        return $urandom_range(8192, 2049);
    endfunction

    // Present one item and hold it until the accept edge. Returns at that
    // edge, so the caller may chain the next item without dropping start.
    task automatic send_item(input t_kind kind, input int number);
        i_start  <= 1'b1;
        i_kind   <= kind;
        i_number <= number[LIMIT_W-1:0];
        do @(posedge i_clk); while (o_busy);
        if (kind == KIND_BUILD && eff_limit(cur_limit) > max_built)
            max_built = eff_limit(cur_limit);
    endtask

    // Drop start for a number of cycles; scramble the payload meanwhile.
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            i_start  <= 1'b0;
            i_kind   <= 1'($urandom);
            i_number <= LIMIT_W'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Sender pacing: bursts of back-to-back items split by random gaps,
    // with an occasional long unbroken stretch.
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(80, 40)
                                                  : $urandom_range(24, 1);
            hold_off(($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                              : $urandom_range(5, 1));
        end else begin
            burst_left--;
        end
    endtask

    // Drop start and wait until every outstanding item has its result.
    task automatic wait_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Write the limit register; upper data bits carry noise.
    task automatic apb_write(input int value);
        logic [APB_DW-1:0] word;
        word               = $urandom;
        word[LIMIT_W-1:0]  = value[LIMIT_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LIMIT;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_limit = value & TOP_NUMBER;
        // Leave the bus idle before the next transfer.
        @(posedge i_clk);
    endtask

    // Read the limit register back; the checker compares the data.
    task automatic apb_read();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LIMIT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // Leave the bus idle before the next transfer.
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int    full_checks [] = '{0, 1, 2, 3, 4, 43690, 63001, 65025, 65521, 65535};
        int    phase_items;
        t_kind kind;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full table at the reset limit: ends of the number range, large
        // squares, the largest 16-bit prime.
        apb_read();
        send_item(KIND_BUILD, $urandom_range(TOP_NUMBER));
        foreach (full_checks[i])
            send_item(KIND_QUERY, full_checks[i]);

        // Limit of two: only 2 is prime, 3 and up are out of range.
        wait_results();
        apb_write(2);
        apb_read();
        send_item(KIND_BUILD, TOP_NUMBER);
        send_item(KIND_QUERY, 2);
        send_item(KIND_QUERY, 3);
        send_item(KIND_QUERY, TOP_NUMBER);

        // Limit below two: nothing is prime, rebuild touches only 0..limit.
        wait_results();
        apb_write(1);
        send_item(KIND_BUILD, 0);
        send_item(KIND_QUERY, 1);
        send_item(KIND_QUERY, 2);
        wait_results();
        apb_write(0);
        send_item(KIND_BUILD, 0);
        send_item(KIND_QUERY, 0);
        send_item(KIND_QUERY, 1);

        // Raise the limit without a rebuild: marks above the small tables
        // still hold what the full rebuild wrote.
        wait_results();
        apb_write(100);
        send_item(KIND_QUERY, 97);
        send_item(KIND_QUERY, 2);
        send_item(KIND_QUERY, 100);
        send_item(KIND_QUERY, 101);

        // Random phases: new limit, usually a rebuild, then a query stream
        // with the odd rebuild mixed in.
        while (random_sent < RANDOM_ITEMS) begin
            wait_results();
            apb_write(pick_limit());
            if ($urandom_range(1))
                apb_read();
            if ($urandom_range(3) != 0) begin
                send_item(KIND_BUILD, $urandom_range(TOP_NUMBER));
                random_sent++;
                pace();
            end
            phase_items = $urandom_range(90, 30);
            repeat (phase_items) begin
                kind = ($urandom_range(49) == 0) ? KIND_BUILD : KIND_QUERY;
                send_item(kind, (kind == KIND_BUILD) ? int'($urandom_range(TOP_NUMBER))
                                                     : pick_query());
                random_sent++;
                pace();
            end
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** prime_sieve_table_core: PASSED **");
        else
            $display("** prime_sieve_table_core: FAILED **");
        $finish;
    end

endmodule
